// ===== rtl/fisheye_project_to_pixel_core_defines.svh =====
// Assertion macros shared by the checker of the fisheye projection core.
`ifndef FISHEYE_PROJECT_TO_PIXEL_CORE_DEFINES_SVH
`define FISHEYE_PROJECT_TO_PIXEL_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FPP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define FPP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fpp_pkg.sv =====
// Shared types, constants and tables of the fisheye projection core.
package fpp_pkg;

  // Default sizes of the coefficient store and the angle iteration.
  localparam int MAX_TERMS_DEF   = 16;
  localparam int ANGLE_STEPS_DEF = 24;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_AFFINE_C   = 3'd2,
    REG_AFFINE_D   = 3'd3,
    REG_AFFINE_E   = 3'd4,
    REG_POLY_TERMS = 3'd5
  } cfg_reg_t;

  // Reset value of affine_c: 1.0 in Q2.30.
  localparam logic signed [31:0] AFFINE_ONE = 32'sh4000_0000;

  // Polynomial accumulator saturation bounds, +-2^55.
  localparam logic signed [63:0] RHO_LIM = 64'sh0080_0000_0000_0000;
  localparam logic signed [63:0] RHO_NEG = 64'shFF80_0000_0000_0000;

  // Normalization thresholds for the angle unit: 2^51 and 2^59.
  localparam logic [59:0] NORM_COARSE = 60'h008_0000_0000_0000;
  localparam logic [59:0] NORM_TARGET = 60'h800_0000_0000_0000;

  // Operations of the shared multiplier; each selects its operands and where its product goes.
  typedef enum logic [2:0] {
    OP_XX     = 3'd0,
    OP_YY     = 3'd1,
    OP_HORNER = 3'd2,
    OP_RX     = 3'd3,
    OP_RY     = 3'd4,
    OP_XC     = 3'd5,
    OP_YD     = 3'd6,
    OP_XE     = 3'd7
  } mul_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_point;
    logic    coef_write;
    logic    mul_go;
    mul_op_t mul_op;
    logic    sqrt_start;
    logic    angle_start;
    logic    div_start;
    logic    k_load;
    logic    k_dec;
    logic    acc_init;
    logic    out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mul_done;
    logic sqrt_done;
    logic norm_zero;
    logic cordic_done;
    logic div_busy;
    logic k_zero;
    logic out_free;
  } sts_t;

  // Arctangent of 2^-i in Q2.30.
  function automatic logic signed [31:0] atan_q30(input logic [5:0] idx);
    logic signed [31:0] v;
    case (idx)
      6'd0:  v = 32'sd843314856;
      6'd1:  v = 32'sd497837829;
      6'd2:  v = 32'sd263043836;
      6'd3:  v = 32'sd133525158;
      6'd4:  v = 32'sd67021686;
      6'd5:  v = 32'sd33543515;
      6'd6:  v = 32'sd16775850;
      6'd7:  v = 32'sd8388437;
      6'd8:  v = 32'sd4194282;
      6'd9:  v = 32'sd2097149;
      6'd10: v = 32'sd1048575;
      6'd11: v = 32'sd524287;
      6'd12: v = 32'sd262143;
      6'd13: v = 32'sd131071;
      6'd14: v = 32'sd65535;
      6'd15: v = 32'sd32767;
      6'd16: v = 32'sd16383;
      6'd17: v = 32'sd8191;
      6'd18: v = 32'sd4095;
      6'd19: v = 32'sd2047;
      6'd20: v = 32'sd1023;
      6'd21: v = 32'sd511;
      6'd22: v = 32'sd255;
      6'd23: v = 32'sd127;
      6'd24: v = 32'sd63;
      6'd25: v = 32'sd31;
      6'd26: v = 32'sd15;
      6'd27: v = 32'sd8;
      6'd28: v = 32'sd4;
      6'd29: v = 32'sd2;
      6'd30: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  // Saturate a pixel sum to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic [43:0] v);
    logic [31:0] r;
    if ((v[43:31] == 13'h0000) || (v[43:31] == 13'h1FFF)) begin
      r = v[31:0];
    end else if (v[43]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

// ===== rtl/fpp_ctrl.sv =====
// Sequencing state machine of the fisheye projection core.
module fpp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          kind,
  output logic          in_ready,
  input  fpp_pkg::sts_t sts,
  output fpp_pkg::cmd_t cmd
);

  typedef enum logic [18:0] {
    S_IDLE  = 19'h00001,
    S_PREP  = 19'h00002,
    S_SQX   = 19'h00004,
    S_SQY   = 19'h00008,
    S_ROOT  = 19'h00010,
    S_NCHK  = 19'h00020,
    S_ANGLE = 19'h00040,
    S_HLD   = 19'h00080,
    S_HRD   = 19'h00100,
    S_HACC  = 19'h00200,
    S_HGO   = 19'h00400,
    S_HMUL  = 19'h00800,
    S_DIVW  = 19'h01000,
    S_MRX   = 19'h02000,
    S_MRY   = 19'h04000,
    S_MXC   = 19'h08000,
    S_MYD   = 19'h10000,
    S_MXE   = 19'h20000,
    S_OUT   = 19'h40000
  } state_t;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (kind) begin
            cmd.load_point = 1'b1;
            state_next     = S_PREP;
          end else begin
            cmd.coef_write = 1'b1;
          end
        end
      end
      S_PREP: begin
        cmd.mul_go = 1'b1;
        cmd.mul_op = fpp_pkg::OP_XX;
        state_next = S_SQX;
      end
      S_SQX: begin
        if (sts.mul_done) begin
          cmd.mul_go = 1'b1;
          cmd.mul_op = fpp_pkg::OP_YY;
          state_next = S_SQY;
        end
      end
      S_SQY: begin
        if (sts.mul_done) begin
          cmd.sqrt_start = 1'b1;
          state_next     = S_ROOT;
        end
      end
      S_ROOT: begin
        if (sts.sqrt_done) begin
          state_next = S_NCHK;
        end
      end
      S_NCHK: begin
        if (sts.norm_zero) begin
          state_next = S_OUT;
        end else begin
          cmd.angle_start = 1'b1;
          cmd.div_start   = 1'b1;
          state_next      = S_ANGLE;
        end
      end
      S_ANGLE: begin
        if (sts.cordic_done) begin
          state_next = S_HLD;
        end
      end
      S_HLD: begin
        cmd.k_load = 1'b1;
        state_next = S_HRD;
      end
      S_HRD: begin
        state_next = S_HACC;
      end
      S_HACC: begin
        cmd.acc_init = 1'b1;
        state_next   = S_HGO;
      end
      S_HGO: begin
        if (sts.k_zero) begin
          state_next = S_DIVW;
        end else begin
          cmd.k_dec  = 1'b1;
          cmd.mul_go = 1'b1;
          cmd.mul_op = fpp_pkg::OP_HORNER;
          state_next = S_HMUL;
        end
      end
      S_HMUL: begin
        if (sts.mul_done) begin
          if (sts.k_zero) begin
            state_next = S_DIVW;
          end else begin
            cmd.k_dec  = 1'b1;
            cmd.mul_go = 1'b1;
            cmd.mul_op = fpp_pkg::OP_HORNER;
          end
        end
      end
      S_DIVW: begin
        if (!sts.div_busy) begin
          cmd.mul_go = 1'b1;
          cmd.mul_op = fpp_pkg::OP_RX;
          state_next = S_MRX;
        end
      end
      S_MRX: begin
        if (sts.mul_done) begin
          cmd.mul_go = 1'b1;
          cmd.mul_op = fpp_pkg::OP_RY;
          state_next = S_MRY;
        end
      end
      S_MRY: begin
        if (sts.mul_done) begin
          cmd.mul_go = 1'b1;
          cmd.mul_op = fpp_pkg::OP_XC;
          state_next = S_MXC;
        end
      end
      S_MXC: begin
        if (sts.mul_done) begin
          cmd.mul_go = 1'b1;
          cmd.mul_op = fpp_pkg::OP_YD;
          state_next = S_MYD;
        end
      end
      S_MYD: begin
        if (sts.mul_done) begin
          cmd.mul_go = 1'b1;
          cmd.mul_op = fpp_pkg::OP_XE;
          state_next = S_MXE;
        end
      end
      S_MXE: begin
        if (sts.mul_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/fpp_datapath.sv =====
// Datapath of the fisheye projection core: root, angle, divide, multiply units.
module fpp_datapath #(
  parameter int MAX_TERMS   = fpp_pkg::MAX_TERMS_DEF,
  parameter int ANGLE_STEPS = fpp_pkg::ANGLE_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [fpp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fpp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [3:0]                      coef_index,
  input  logic signed [47:0]              coef_value,
  input  logic signed [31:0]              point_x,
  input  logic signed [31:0]              point_y,
  input  logic signed [31:0]              point_z,
  input  fpp_pkg::cmd_t                   cmd,
  output fpp_pkg::sts_t                   sts,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic signed [31:0]              pixel_x,
  output logic signed [31:0]              pixel_y,
  output logic                            at_center
);

  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW = $clog2(ANGLE_STEPS);

  // Configuration registers.
  logic signed [31:0] center_x, center_y, affine_c, affine_d, affine_e;
  logic [4:0]         poly_terms;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x   <= '0;
      center_y   <= '0;
      affine_c   <= fpp_pkg::AFFINE_ONE;
      affine_d   <= '0;
      affine_e   <= '0;
      poly_terms <= 5'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        fpp_pkg::REG_CENTER_X:   center_x   <= cfg_data;
        fpp_pkg::REG_CENTER_Y:   center_y   <= cfg_data;
        fpp_pkg::REG_AFFINE_C:   affine_c   <= cfg_data;
        fpp_pkg::REG_AFFINE_D:   affine_d   <= cfg_data;
        fpp_pkg::REG_AFFINE_E:   affine_e   <= cfg_data;
        fpp_pkg::REG_POLY_TERMS: poly_terms <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Captured ray of the item in progress.
  logic signed [31:0] pt_x, pt_y, pt_z;

  always_ff @(posedge clk) begin
    if (cmd.load_point) begin
      pt_x <= point_x;
      pt_y <= point_y;
      pt_z <= point_z;
    end
  end

  // Coefficient store with registered read at the term counter.
  logic signed [47:0] coef_mem [MAX_TERMS];
  logic signed [47:0] coef_rd;
  logic [AW-1:0]      k;
  logic [5:0]         nm1;

  always_ff @(posedge clk) begin
    if (cmd.coef_write && (32'(coef_index) < MAX_TERMS)) begin
      coef_mem[AW'(coef_index)] <= coef_value;
    end
    coef_rd <= coef_mem[k];
  end

  // Highest coefficient in use; a count of zero acts as one.
  always_comb begin
    if (poly_terms == 5'd0) begin
      nm1 = 6'd0;
    end else if ({1'b0, poly_terms} > 6'(MAX_TERMS)) begin
      nm1 = 6'(MAX_TERMS - 1);
    end else begin
      nm1 = {1'b0, poly_terms} - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.k_load) begin
      k <= nm1[AW-1:0];
    end else if (cmd.k_dec) begin
      k <= k - 1'b1;
    end
  end

  // Square root: one result bit per cycle.
  logic [63:0] sq;
  logic [63:0] rad;
  logic [31:0] root;
  logic [35:0] srem;
  logic [4:0]  scnt;
  logic        sbusy, sdone;
  logic [35:0] s_t, s_trial;
  logic        s_ge;

  assign s_t     = {srem[33:0], rad[63:62]};
  assign s_trial = {2'b00, root, 2'b01};
  assign s_ge    = (s_t >= s_trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      sbusy <= 1'b0;
      sdone <= 1'b0;
    end else begin
      sdone <= 1'b0;
      if (cmd.sqrt_start) begin
        sbusy <= 1'b1;
      end else if (sbusy && (scnt == 5'd31)) begin
        sbusy <= 1'b0;
        sdone <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      rad  <= sq;
      root <= '0;
      srem <= '0;
      scnt <= '0;
    end else if (sbusy) begin
      rad  <= {rad[61:0], 2'b00};
      scnt <= scnt + 5'd1;
      if (s_ge) begin
        srem <= s_t - s_trial;
        root <= {root[30:0], 1'b1};
      end else begin
        srem <= s_t;
        root <= {root[30:0], 1'b0};
      end
    end
  end

  // Angle unit: normalize, then one vectoring rotation per cycle.
  logic signed [63:0] cx, cy, cdx, cdy;
  logic [59:0]        cm;
  logic signed [31:0] ang, atan_i;
  logic [CW-1:0]      ci;
  logic               cbusy, cnorm, cdone;
  logic [32:0]        z_abs;

  assign z_abs  = pt_z[31] ? (33'd0 - {pt_z[31], pt_z}) : {1'b0, pt_z};
  assign cdx    = cy >>> ci;
  assign cdy    = cx >>> ci;
  assign atan_i = fpp_pkg::atan_q30(6'(ci));

  always_ff @(posedge clk) begin
    if (rst) begin
      cbusy <= 1'b0;
      cdone <= 1'b0;
    end else begin
      cdone <= 1'b0;
      if (cmd.angle_start) begin
        cbusy <= 1'b1;
      end else if (cbusy && !cnorm && (ci == CW'(ANGLE_STEPS - 1))) begin
        cbusy <= 1'b0;
        cdone <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.angle_start) begin
      cx    <= {32'd0, root};
      cy    <= {{32{pt_z[31]}}, pt_z};
      cm    <= (z_abs > {1'b0, root}) ? {27'd0, z_abs} : {28'd0, root};
      ang   <= '0;
      ci    <= '0;
      cnorm <= 1'b1;
    end else if (cbusy && cnorm) begin
      if (cm < fpp_pkg::NORM_COARSE) begin
        cx <= cx <<< 8;
        cy <= cy <<< 8;
        cm <= cm << 8;
      end else if (cm < fpp_pkg::NORM_TARGET) begin
        cx <= cx <<< 1;
        cy <= cy <<< 1;
        cm <= cm << 1;
      end else begin
        cnorm <= 1'b0;
      end
    end else if (cbusy) begin
      ci <= ci + 1'b1;
      if (!cy[63]) begin
        cx  <= cx + cdx;
        cy  <= cy - cdy;
        ang <= ang + atan_i;
      end else begin
        cx  <= cx - cdx;
        cy  <= cy + cdy;
        ang <= ang - atan_i;
      end
    end
  end

  // Two restoring dividers for x and y over the norm, one quotient bit a cycle.
  logic [31:0]        dvd, dv_remx, dv_remy;
  logic [30:0]        dv_qx, dv_qy;
  logic               dv_sx, dv_sy, dv_bx, dv_by, dv_busy;
  logic [4:0]         dv_cnt;
  logic [32:0]        x_abs, y_abs, tx, ty;
  logic               gex, gey;
  logic signed [31:0] rx, ry;

  assign x_abs = pt_x[31] ? (33'd0 - {pt_x[31], pt_x}) : {1'b0, pt_x};
  assign y_abs = pt_y[31] ? (33'd0 - {pt_y[31], pt_y}) : {1'b0, pt_y};
  assign tx    = {dv_remx, (dv_cnt == 5'd0) ? dv_bx : 1'b0};
  assign ty    = {dv_remy, (dv_cnt == 5'd0) ? dv_by : 1'b0};
  assign gex   = (tx >= {1'b0, dvd});
  assign gey   = (ty >= {1'b0, dvd});
  assign rx    = dv_sx ? (32'd0 - {1'b0, dv_qx}) : {1'b0, dv_qx};
  assign ry    = dv_sy ? (32'd0 - {1'b0, dv_qy}) : {1'b0, dv_qy};

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_busy <= 1'b0;
    end else if (cmd.div_start) begin
      dv_busy <= 1'b1;
    end else if (dv_busy && (dv_cnt == 5'd30)) begin
      dv_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd     <= root;
      dv_remx <= x_abs[32:1];
      dv_remy <= y_abs[32:1];
      dv_bx   <= x_abs[0];
      dv_by   <= y_abs[0];
      dv_sx   <= pt_x[31];
      dv_sy   <= pt_y[31];
      dv_qx   <= '0;
      dv_qy   <= '0;
      dv_cnt  <= '0;
    end else if (dv_busy) begin
      dv_cnt  <= dv_cnt + 5'd1;
      dv_remx <= gex ? 32'(tx - {1'b0, dvd}) : tx[31:0];
      dv_remy <= gey ? 32'(ty - {1'b0, dvd}) : ty[31:0];
      dv_qx   <= {dv_qx[29:0], gex};
      dv_qy   <= {dv_qy[29:0], gey};
    end
  end

  // Shared multiplier: 64x32 signed as two partial products, then a sum.
  logic signed [56:0] acc, xd, yd;
  logic signed [58:0] sx, sy;
  logic signed [63:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] mul_lo;
  logic signed [63:0] mul_hi;
  logic signed [95:0] prod;
  logic signed [63:0] q30, hsum;
  logic signed [56:0] horner_next;
  fpp_pkg::mul_op_t   op1, op2;
  logic               m1, m2, m3;

  always_comb begin
    case (cmd.mul_op)
      fpp_pkg::OP_XX: begin
        mul_a = {{32{pt_x[31]}}, pt_x};
        mul_b = pt_x;
      end
      fpp_pkg::OP_YY: begin
        mul_a = {{32{pt_y[31]}}, pt_y};
        mul_b = pt_y;
      end
      fpp_pkg::OP_HORNER: begin
        mul_a = {{7{acc[56]}}, acc};
        mul_b = ang;
      end
      fpp_pkg::OP_RX: begin
        mul_a = {{7{acc[56]}}, acc};
        mul_b = rx;
      end
      fpp_pkg::OP_RY: begin
        mul_a = {{7{acc[56]}}, acc};
        mul_b = ry;
      end
      fpp_pkg::OP_XC: begin
        mul_a = {{7{xd[56]}}, xd};
        mul_b = affine_c;
      end
      fpp_pkg::OP_YD: begin
        mul_a = {{7{yd[56]}}, yd};
        mul_b = affine_d;
      end
      fpp_pkg::OP_XE: begin
        mul_a = {{7{xd[56]}}, xd};
        mul_b = affine_e;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1 <= 1'b0;
      m2 <= 1'b0;
      m3 <= 1'b0;
    end else begin
      m1 <= cmd.mul_go;
      m2 <= m1;
      m3 <= m2;
    end
  end

  always_ff @(posedge clk) begin
    mul_lo <= $signed({1'b0, mul_a[31:0]}) * mul_b;
    mul_hi <= $signed(mul_a[63:32]) * mul_b;
    op1    <= cmd.mul_op;
    prod   <= {mul_hi, 32'd0} + {{31{mul_lo[64]}}, mul_lo};
    op2    <= op1;
  end

  // Product floored to Q30 and the saturated polynomial step.
  assign q30  = prod[93:30];
  assign hsum = q30 + {{16{coef_rd[47]}}, coef_rd};

  always_comb begin
    if (hsum > fpp_pkg::RHO_LIM) begin
      horner_next = fpp_pkg::RHO_LIM[56:0];
    end else if (hsum < fpp_pkg::RHO_NEG) begin
      horner_next = fpp_pkg::RHO_NEG[56:0];
    end else begin
      horner_next = hsum[56:0];
    end
  end

  // Products land in the register that their operation selects.
  always_ff @(posedge clk) begin
    if (cmd.acc_init) begin
      acc <= {{9{coef_rd[47]}}, coef_rd};
    end else if (m2 && (op2 == fpp_pkg::OP_HORNER)) begin
      acc <= horner_next;
    end
    if (m2) begin
      case (op2)
        fpp_pkg::OP_XX: sq <= prod[63:0];
        fpp_pkg::OP_YY: sq <= sq + prod[63:0];
        fpp_pkg::OP_RX: xd <= q30[56:0];
        fpp_pkg::OP_RY: yd <= q30[56:0];
        fpp_pkg::OP_XC: sx <= q30[58:0];
        fpp_pkg::OP_YD: sx <= sx + q30[58:0];
        fpp_pkg::OP_XE: sy <= q30[58:0] + {{2{yd[56]}}, yd};
        default: ;
      endcase
    end
  end

  // Output register: pixel sums scaled to Q16.16, centered and saturated.
  logic [43:0] px_sum, py_sum;
  logic        norm_zero;

  assign norm_zero = (root == 32'd0);
  assign px_sum    = {sx[58], sx[58:16]} + {{12{center_x[31]}}, center_x};
  assign py_sum    = {sy[58], sy[58:16]} + {{12{center_y[31]}}, center_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      at_center <= norm_zero;
      if (norm_zero) begin
        pixel_x <= center_x;
        pixel_y <= center_y;
      end else begin
        pixel_x <= fpp_pkg::sat32(px_sum);
        pixel_y <= fpp_pkg::sat32(py_sum);
      end
    end
  end

  // Status back to the controller.
  always_comb begin
    sts.mul_done    = m3;
    sts.sqrt_done   = sdone;
    sts.norm_zero   = norm_zero;
    sts.cordic_done = cdone;
    sts.div_busy    = dv_busy;
    sts.k_zero      = (k == '0);
    sts.out_free    = !out_valid || out_ready;
  end

endmodule

// ===== rtl/fisheye_project_to_pixel_core.sv =====
// Top level of the fisheye projection core.
//
// Input channel (in_valid/in_ready): kind 0 writes coef_value into slot
// coef_index of the coefficient store, yields no result and leaves the
// block ready. Kind 1 projects the ray (point_x, point_y, point_z) and
// yields one pixel on the output channel (out_valid/out_ready).
// One item is worked on at a time. The time a projection takes grows with
// poly_terms (counted after clamping to 1..MAX_TERMS) and varies with the
// normalizing of the ray ahead of the angle steps. A ray on the axis (zero
// in-plane norm) skips the angle, divide and polynomial steps. The time is
// set by the bit-serial square root, the 24-step angle iteration and the
// shared multiplier, which is used 6 + poly_terms times per projection.
// Configuration writes (cfg_write/cfg_index/cfg_data) land at once.
// Reset clears the controller and resets the configuration registers; the
// coefficient store keeps no reset value and must be loaded before use.
// A result waits in the output register while the receiver stalls; the
// next item is taken meanwhile and its result waits until that register frees.
module fisheye_project_to_pixel_core #(
  parameter int MAX_TERMS   = fpp_pkg::MAX_TERMS_DEF,
  parameter int ANGLE_STEPS = fpp_pkg::ANGLE_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [fpp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fpp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            kind,
  input  logic [3:0]                      coef_index,
  input  logic signed [47:0]              coef_value,
  input  logic signed [31:0]              point_x,
  input  logic signed [31:0]              point_y,
  input  logic signed [31:0]              point_z,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [31:0]              pixel_x,
  output logic signed [31:0]              pixel_y,
  output logic                            at_center
);

  fpp_pkg::cmd_t cmd;
  fpp_pkg::sts_t sts;

  // Controller.
  fpp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath.
  fpp_datapath #(
    .MAX_TERMS   (MAX_TERMS),
    .ANGLE_STEPS (ANGLE_STEPS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .coef_index (coef_index),
    .coef_value (coef_value),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .at_center  (at_center)
  );

endmodule

// ===== rtl/fpp_checker.sv =====
// Port-level checker of the fisheye projection core and its bind.
`include "fisheye_project_to_pixel_core_defines.svh"

module fpp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        kind,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] pixel_x,
  input logic [31:0] pixel_y,
  input logic        at_center
);

  // A stalled result holds.
  `FPP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(at_center), "stalled result changed")

  // A projection is never finished in the cycle after it is taken.
  `FPP_ASSERT_NEXT(a_no_instant, in_valid && in_ready && kind, !$rose(out_valid), "result too early")

  // The block is busy right after taking a projection.
  `FPP_ASSERT_NEXT(a_busy, in_valid && in_ready && kind, !in_ready, "ready while busy")

  // The block takes input again once a result is posted.
  `FPP_ASSERT_NOW(a_ready_after, $rose(out_valid), in_ready, "not ready after result")

endmodule

bind fisheye_project_to_pixel_core fpp_checker u_fpp_checker (.*);

// ===== verif/tb.sv =====
// Testbench for the fisheye projection core: directed table, random items, predictor check.
`timescale 1ns / 1ps

module tb;

  localparam logic [fpp_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [fpp_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_PROJECT = 1'b1;
  localparam int STORE_DEPTH = 16;
  localparam int CORDIC_STEPS = 24;
  localparam longint RHO_BOUND = 64'sd1 <<< 55;

  // Arctangent of 2^-i in Q2.30, for the angle predictor.
  localparam longint ATAN_TAB [0:23] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};

  typedef struct {
    logic [31:0] px;
    logic [31:0] py;
    logic        ac;
  } pixel_t;

  typedef struct {
    logic        kind;
    logic [3:0]  idx;
    logic [47:0] val;
    logic [31:0] x, y, z;
    bit          fixed;
    pixel_t      want;
  } row_t;

  logic clk, rst;
  logic cfg_write;
  logic [fpp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [fpp_pkg::CFG_DATA_W-1:0] cfg_data;
  logic in_valid, in_ready, kind;
  logic [3:0] coef_index;
  logic signed [47:0] coef_value;
  logic signed [31:0] point_x, point_y, point_z;
  logic out_valid, out_ready;
  logic signed [31:0] pixel_x, pixel_y;
  logic at_center;

  // Predictor copy of the configuration and the coefficient store.
  longint cen_x, cen_y, aff_c, aff_d, aff_e;
  int unsigned term_cnt;
  longint coef_mem [STORE_DEPTH];

  pixel_t pending_pixels [$];
  int err_cnt;
  int tx_idle_pct, rx_idle_pct;
  bit hold_req;

  fisheye_project_to_pixel_core u_top (.*);

  // Clock.
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v = v - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic longint ray_angle(longint norm, longint z);
    longint unsigned m, az;
    longint xs, ys, ang, dx, dy;
    m = norm;
    az = (z < 0) ? -z : z;
    ang = 0;
    if (az > m) m = az;
    xs = norm;
    ys = z;
    // Normalize both values together until the larger reaches 2^59.
    while (m < (64'd1 << 59)) begin
      m = m << 1;
      xs = xs * 2;
      ys = ys * 2;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = ys >>> i;
      dy = xs >>> i;
      if (ys >= 0) begin
        xs += dx; ys -= dy; ang += ATAN_TAB[i];
      end else begin
        xs -= dx; ys += dy; ang -= ATAN_TAB[i];
      end
    end
    return ang;
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    longint hi, lo;
    hi = a >>> 30;
    lo = a - (hi <<< 30);
    return hi * b + ((lo * b) >>> 30);
  endfunction

  function automatic longint clamp_poly(longint v);
    if (v > RHO_BOUND) return RHO_BOUND;
    if (v < -RHO_BOUND) return -RHO_BOUND;
    return v;
  endfunction

  function automatic logic [31:0] clip32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // Expected pixel of one ray under the current configuration.
  function automatic pixel_t project_ray(logic [31:0] xr, logic [31:0] yr, logic [31:0] zr);
    pixel_t p;
    longint x, y, z, norm, theta, rho, rx, ry, xd, yd;
    int unsigned n;
    x = longint'($signed(xr));
    y = longint'($signed(yr));
    z = longint'($signed(zr));
    norm = longint'(int_sqrt(longint'(x * x) + longint'(y * y)));
    if (norm == 0) begin
      p.px = clip32(cen_x);
      p.py = clip32(cen_y);
      p.ac = 1'b1;
      return p;
    end
    theta = ray_angle(norm, z);
    n = term_cnt;
    if (n < 1) n = 1;
    if (n > STORE_DEPTH) n = STORE_DEPTH;
    rho = clamp_poly(coef_mem[n-1]);
    for (int k = n - 1; k > 0; k--) rho = clamp_poly(q30_mul(rho, theta) + coef_mem[k-1]);
    rx = (x <<< 30) / norm;
    ry = (y <<< 30) / norm;
    xd = q30_mul(rho, rx);
    yd = q30_mul(rho, ry);
    p.px = clip32(((q30_mul(xd, aff_c) + q30_mul(yd, aff_d)) >>> 16) + cen_x);
    p.py = clip32(((q30_mul(xd, aff_e) + yd) >>> 16) + cen_y);
    p.ac = 1'b0;
    return p;
  endfunction

  // One register write; the port is then left quiet before the task returns.
  task automatic write_reg(logic [fpp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      fpp_pkg::REG_CENTER_X:   cen_x = longint'($signed(val));
      fpp_pkg::REG_CENTER_Y:   cen_y = longint'($signed(val));
      fpp_pkg::REG_AFFINE_C:   aff_c = longint'($signed(val));
      fpp_pkg::REG_AFFINE_D:   aff_d = longint'($signed(val));
      fpp_pkg::REG_AFFINE_E:   aff_e = longint'($signed(val));
      fpp_pkg::REG_POLY_TERMS: term_cnt = 32'(val[4:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one item, with a random gap first, and update the predictor on acceptance.
  task automatic send_item(row_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= r.kind;
    coef_index <= r.idx;
    coef_value <= r.val;
    point_x <= r.x;
    point_y <= r.y;
    point_z <= r.z;
    do @(posedge clk); while (!in_ready);
    if (r.kind == KIND_LOAD) begin
      coef_mem[r.idx] = longint'($signed(r.val));
    end else if (r.fixed) begin
      pending_pixels.insert(pending_pixels.size(), r.want);
    end else begin
      pending_pixels.insert(pending_pixels.size(), project_ray(r.x, r.y, r.z));
    end
  endtask

  // Block is idle once every result is out and any load has settled.
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0: return 32'h0;
      1, 2: return $urandom;
      3: return 32'($signed($urandom_range(16)) - 8);
      4: return (($urandom_range(1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF);
      5: return 32'($signed($urandom_range(2097152)) - 1048576);
      default: return 32'($signed($urandom_range(33554432)) - 16777216);
    endcase
  endfunction

  function automatic row_t rand_row();
    row_t r;
    r.fixed = 1'b0;
    r.want = '{default: 0};
    r.idx = 4'($urandom_range(15));
    r.val = 48'($signed({$urandom, $urandom}) >>> $urandom_range(47));
    r.kind = ($urandom_range(99) < 20) ? KIND_LOAD : KIND_PROJECT;
    r.x = rand_coord();
    r.y = ($urandom_range(9) == 0) ? 32'h0 : rand_coord();
    if ($urandom_range(9) == 0) r.x = 32'h0;
    r.z = rand_coord();
    return r;
  endfunction

  // Result check against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $error("result with no item waiting: pixel_x %0d pixel_y %0d", pixel_x, pixel_y);
        err_cnt++;
      end else begin
        pixel_t w;
        w = pending_pixels.pop_front();
        if (pixel_x !== w.px) begin
          $error("pixel_x expected %0d actual %0d", $signed(w.px), pixel_x);
          err_cnt++;
        end
        if (pixel_y !== w.py) begin
          $error("pixel_y expected %0d actual %0d", $signed(w.py), pixel_y);
          err_cnt++;
        end
        if (at_center !== w.ac) begin
          $error("at_center expected %0d actual %0d", w.ac, at_center);
          err_cnt++;
        end
      end
    end
  end

  // Receiver: random stalls, and one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Run limit.
  initial begin
    #8ms;
    $display("fisheye_project_to_pixel_core verification failed");
    $finish;
  end

  initial begin
    row_t dir_rows [$];
    row_t r;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    kind = 1'b0;
    coef_index = '0;
    coef_value = '0;
    point_x = '0;
    point_y = '0;
    point_z = '0;
    err_cnt = 0;
    hold_req = 1'b0;
    tx_idle_pct = 10;
    rx_idle_pct = 82;
    cen_x = 0; cen_y = 0;
    aff_c = longint'(fpp_pkg::AFFINE_ONE); aff_d = 0; aff_e = 0;
    term_cnt = 1;
    foreach (coef_mem[i]) coef_mem[i] = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: load every slot, extremes among them, then edge rays.
    for (int i = 0; i < STORE_DEPTH; i++) begin
      r = '{kind: KIND_LOAD, idx: 4'(i), val: 48'($signed(i * 37 - 200) <<< 28),
            x: 0, y: 0, z: 0, fixed: 1'b0, want: '{default: 0}};
      if (i == 0) r.val = 48'sd500 <<< 32;
      if (i == 14) r.val = 48'h7FFF_FFFF_FFFF;
      if (i == 15) r.val = 48'h8000_0000_0000;
      dir_rows.insert(dir_rows.size(), r);
    end
    // Rays on the axis return the center, which is zero after reset.
    dir_rows.insert(dir_rows.size(), '{KIND_PROJECT, 4'd0, 48'd0, 32'h0, 32'h0,
                    32'h0001_0000, 1'b1, '{32'h0, 32'h0, 1'b1}});
    dir_rows.insert(dir_rows.size(), '{KIND_PROJECT, 4'hF, 48'hFFFF_FFFF_FFFF, 32'h0,
                    32'h0, 32'h8000_0000, 1'b1, '{32'h0, 32'h0, 1'b1}});
    dir_rows.insert(dir_rows.size(), '{KIND_PROJECT, 4'd0, 48'd0, 32'h7FFF_FFFF, 32'h0,
                    32'h0, 1'b0, '{default: 0}});
    dir_rows.insert(dir_rows.size(), '{KIND_PROJECT, 4'd0, 48'd0, 32'h8000_0000,
                    32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '{default: 0}});
    dir_rows.insert(dir_rows.size(), '{KIND_PROJECT, 4'd0, 48'd0, 32'h1, 32'h0,
                    32'h8000_0000, 1'b0, '{default: 0}});
    dir_rows.insert(dir_rows.size(), '{KIND_PROJECT, 4'd0, 48'd0, 32'h0, 32'hFFFF_FFFF,
                    32'h0, 1'b0, '{default: 0}});
    dir_rows.insert(dir_rows.size(), '{KIND_PROJECT, 4'd0, 48'd0, 32'hFFFF_0000,
                    32'h0003_0000, 32'hFFFF_FFFF, 1'b0, '{default: 0}});
    foreach (dir_rows[i]) send_item(dir_rows[i]);

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(fpp_pkg::REG_CENTER_X, 32'd320 << 16);
          write_reg(fpp_pkg::REG_CENTER_Y, 32'd240 << 16);
          write_reg(fpp_pkg::REG_AFFINE_C, fpp_pkg::AFFINE_ONE);
          write_reg(fpp_pkg::REG_AFFINE_D, 32'h0);
          write_reg(fpp_pkg::REG_AFFINE_E, 32'h0);
          write_reg(fpp_pkg::REG_POLY_TERMS, 32'd4);
          write_reg(REG_SPARE_6, $urandom);
        end
        1: begin
          write_reg(fpp_pkg::REG_CENTER_X, 32'h7FFF_FFFF);
          write_reg(fpp_pkg::REG_CENTER_Y, 32'h8000_0000);
          write_reg(fpp_pkg::REG_AFFINE_C, 32'h7FFF_FFFF);
          write_reg(fpp_pkg::REG_AFFINE_D, 32'h8000_0000);
          write_reg(fpp_pkg::REG_AFFINE_E, 32'h7FFF_FFFF);
          write_reg(fpp_pkg::REG_POLY_TERMS, 32'd16);
        end
        2: begin
          write_reg(fpp_pkg::REG_CENTER_X, 32'h8000_0000);
          write_reg(fpp_pkg::REG_CENTER_Y, 32'h7FFF_FFFF);
          write_reg(fpp_pkg::REG_AFFINE_C, 32'h8000_0000);
          write_reg(fpp_pkg::REG_AFFINE_D, 32'h7FFF_FFFF);
          write_reg(fpp_pkg::REG_AFFINE_E, 32'h8000_0000);
          write_reg(fpp_pkg::REG_POLY_TERMS, 32'd31);
          write_reg(REG_SPARE_7, $urandom);
        end
        3: begin
          write_reg(fpp_pkg::REG_CENTER_X, $urandom_range(1 << 26));
          write_reg(fpp_pkg::REG_CENTER_Y, $urandom_range(1 << 26));
          write_reg(fpp_pkg::REG_AFFINE_C, $urandom);
          write_reg(fpp_pkg::REG_AFFINE_D, $urandom);
          write_reg(fpp_pkg::REG_AFFINE_E, $urandom);
          write_reg(fpp_pkg::REG_POLY_TERMS, 32'd0);
          hold_req = 1'b1;
        end
        4: begin
          write_reg(fpp_pkg::REG_AFFINE_D, $urandom >> 4);
          write_reg(fpp_pkg::REG_POLY_TERMS, 32'd17);
        end
        default: begin
          write_reg(fpp_pkg::REG_CENTER_X, 32'h0);
          write_reg(fpp_pkg::REG_CENTER_Y, 32'h0);
          write_reg(fpp_pkg::REG_AFFINE_C, fpp_pkg::AFFINE_ONE);
          write_reg(fpp_pkg::REG_POLY_TERMS, $urandom_range(16, 1));
        end
      endcase
      // Idle pattern: sender light and receiver heavy, then swapped, then none.
      if (ph < 2) begin
        tx_idle_pct = 10; rx_idle_pct = 82;
      end else if (ph < 4) begin
        tx_idle_pct = 82; rx_idle_pct = 10;
      end else begin
        tx_idle_pct = 0; rx_idle_pct = 0;
      end
      for (int n = 0; n < 115; n++) send_item(rand_row());
    end

    drain();
    if (err_cnt == 0) begin
      $display("fisheye_project_to_pixel_core verification clean");
    end else begin
      $display("fisheye_project_to_pixel_core verification failed");
    end
    $finish;
  end

endmodule
